// ----- sv/tcsf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text stream filter package
// Shared codes, character constants and the command word passed from the
// classifying front end to the emitting back end.
// ----------------------------------------------------------------------------
package tcsf_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MODE_FLAGS   = 3'd0,
    REG_DELETE_BYTE  = 3'd1,
    REG_REPLACE_FROM = 3'd2,
    REG_REPLACE_TO   = 3'd3,
    REG_TAB_WIDTH    = 3'd4
  } cfg_reg_e;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned MODE_W      = 7;
  localparam int unsigned TAB_W       = 6;

  // Bit positions inside mode_flags.
  localparam int unsigned MODE_BLANK   = 0;
  localparam int unsigned MODE_DELETE  = 1;
  localparam int unsigned MODE_LOWER   = 2;
  localparam int unsigned MODE_NUMBERS = 3;
  localparam int unsigned MODE_REPLACE = 4;
  localparam int unsigned MODE_UPPER   = 5;
  localparam int unsigned MODE_TABS    = 6;

  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // Depth of the command queue between front and back end.
  localparam int unsigned CMD_FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    BODY_NONE   = 2'd0,
    BODY_BYTE   = 2'd1,
    BODY_SPACES = 2'd2
  } body_kind_e;

  typedef struct packed {
    logic              prefix;
    body_kind_e        kind;
    logic [7:0]        data;
    logic [TAB_W-1:0]  spaces;
  } cmd_t;

endpackage

// ----- sv/tcsf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text stream filter front end
// Holds the configuration, runs each input word through delete, replace and
// case folding, and turns it into at most one command for the back end.
// ----------------------------------------------------------------------------
module tcsf_front import tcsf_pkg::*; #(
  parameter int unsigned MAX_TAB_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   push_i,
  input  logic                   kind_i,
  input  logic [7:0]             in_byte_i,
  input  logic                   fifo_full_i,
  output logic                   cmd_push_o,
  output cmd_t                   cmd_o
);

  logic [MODE_W-1:0] mode_q;
  logic [7:0]        delete_q;
  logic [7:0]        repl_from_q;
  logic [7:0]        repl_to_q;
  logic [TAB_W-1:0]  tab_width_q;
  logic [7:0]        prev_q, prev_d;

  logic              accept;
  logic              deleted;
  logic [7:0]        c_repl, c_upper, c_lower;
  logic [TAB_W-1:0]  n_spaces;
  logic              at_line_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      delete_q    <= '0;
      repl_from_q <= '0;
      repl_to_q   <= '0;
      tab_width_q <= TAB_W'(8);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE_FLAGS:   mode_q      <= cfg_data_i[MODE_W-1:0];
        REG_DELETE_BYTE:  delete_q    <= cfg_data_i;
        REG_REPLACE_FROM: repl_from_q <= cfg_data_i;
        REG_REPLACE_TO:   repl_to_q   <= cfg_data_i;
        REG_TAB_WIDTH:    tab_width_q <= cfg_data_i[TAB_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept  = push_i && !fifo_full_i;
  assign deleted = mode_q[MODE_DELETE] && (in_byte_i == delete_q);

  always_comb begin
    c_repl = (mode_q[MODE_REPLACE] && in_byte_i == repl_from_q) ? repl_to_q : in_byte_i;
    c_upper = c_repl;
    if (mode_q[MODE_UPPER] && c_repl >= 8'h61 && c_repl <= 8'h7A) begin
      c_upper = c_repl - CASE_OFFSET;
    end
    c_lower = c_upper;
    if (mode_q[MODE_LOWER] && c_upper >= 8'h41 && c_upper <= 8'h5A) begin
      c_lower = c_upper + CASE_OFFSET;
    end
  end

  assign n_spaces = (tab_width_q > TAB_W'(MAX_TAB_WIDTH)) ? TAB_W'(MAX_TAB_WIDTH)
                                                          : tab_width_q;
  assign at_line_start = mode_q[MODE_NUMBERS] && (prev_q == CH_NL);

  // Classification. A command that would emit nothing is not queued.
  always_comb begin
    cmd_o.prefix = 1'b0;
    cmd_o.kind   = BODY_NONE;
    cmd_o.data   = c_lower;
    cmd_o.spaces = n_spaces;
    prev_d       = prev_q;
    if (kind_i) begin
      prev_d       = '0;
      cmd_o.prefix = mode_q[MODE_NUMBERS];
    end else if (!deleted) begin
      prev_d = c_lower;
      if (mode_q[MODE_TABS] && c_lower == CH_TAB) begin
        cmd_o.prefix = at_line_start;
        cmd_o.kind   = (n_spaces != '0) ? BODY_SPACES : BODY_NONE;
      end else if (!(mode_q[MODE_BLANK] && c_lower == CH_NL && prev_q == CH_NL)) begin
        cmd_o.prefix = at_line_start;
        cmd_o.kind   = BODY_BYTE;
      end
    end
  end

  assign cmd_push_o = accept && (cmd_o.prefix || cmd_o.kind != BODY_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (accept) begin
      prev_q <= prev_d;
    end
  end

endmodule

// ----- sv/tcsf_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text stream filter command queue
// Short first-in first-out queue that decouples the front and back end.
// ----------------------------------------------------------------------------
module tcsf_cmd_fifo import tcsf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_data_i,
  input  logic rd_i,
  output cmd_t rd_data_o,
  output logic full_o,
  output logic valid_o
);

  localparam int unsigned PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t             mem_q [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == CNT_W'(CMD_FIFO_DEPTH));
  assign valid_o   = (count_q != '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/tcsf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text stream filter back end
// Expands each command into output bytes: the line number prefix, then the
// byte itself or a run of spaces. Owns the BCD line counter.
// ----------------------------------------------------------------------------
module tcsf_back import tcsf_pkg::*; #(
  parameter int unsigned LINE_DIGITS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  localparam int unsigned POS_W = $clog2(LINE_DIGITS + 2);
  localparam int unsigned DIG_W = (LINE_DIGITS > 1) ? $clog2(LINE_DIGITS) : 1;
  localparam logic [LINE_DIGITS*4-1:0] COUNT_RESET = (LINE_DIGITS * 4)'(1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_PREFIX = 3'b010,
    ST_BODY   = 3'b100
  } state_e;

  typedef logic [LINE_DIGITS-1:0][3:0] bcd_t;

  function automatic bcd_t bcd_inc(input bcd_t v);
    bcd_t r;
    logic carry;
    logic nines;
    nines = 1'b1;
    r     = v;
    carry = 1'b1;
    for (int i = 0; i < LINE_DIGITS; i++) begin
      if (v[i] != 4'd9) nines = 1'b0;
      if (carry) begin
        if (v[i] == 4'd9) begin
          r[i] = 4'd0;
        end else begin
          r[i]  = v[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return nines ? v : r;
  endfunction

  state_e           state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             lead_q, lead_d;
  logic [TAB_W-1:0] cnt_q, cnt_d;
  body_kind_e       kind_q, kind_d;
  logic [7:0]       byte_q, byte_d;
  logic [TAB_W-1:0] n_q, n_d;
  bcd_t             count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;

  logic             slot_free, emit, done, load;
  logic [DIG_W-1:0] dig_idx;
  logic [3:0]       digit;
  logic             in_digits, prefix_end, body_end, blank_digit;
  logic [7:0]       emit_byte;

  assign slot_free  = !out_valid_q || pop_i;
  assign emit       = (state_q != ST_IDLE) && slot_free;
  assign dig_idx    = DIG_W'(LINE_DIGITS - 1) - pos_q[DIG_W-1:0];
  assign digit      = count_q[dig_idx];
  assign in_digits  = pos_q < POS_W'(LINE_DIGITS);
  assign prefix_end = pos_q == POS_W'(LINE_DIGITS + 1);
  assign body_end   = (kind_q == BODY_BYTE) || (cnt_q == n_q - TAB_W'(1));
  // Leading zeros show as spaces, except for the units digit.
  assign blank_digit = lead_q && (digit == 4'd0) && (pos_q != POS_W'(LINE_DIGITS - 1));

  always_comb begin
    emit_byte = CH_SPACE;
    done      = 1'b0;
    unique case (state_q)
      ST_PREFIX: begin
        if (in_digits && !blank_digit) begin
          emit_byte = CH_ZERO + {4'd0, digit};
        end
        done = prefix_end && (kind_q == BODY_NONE);
      end
      ST_BODY: begin
        if (kind_q == BODY_BYTE) begin
          emit_byte = byte_q;
        end
        done = body_end;
      end
      default: ;
    endcase
  end

  // The next command is taken in the same cycle as the last byte of the
  // current one, so single-byte commands stream at one per cycle while the output is taken.
  assign load      = cmd_valid_i && ((state_q == ST_IDLE) || (emit && done));
  assign cmd_pop_o = load;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    lead_d      = lead_q;
    cnt_d       = cnt_q;
    kind_d      = kind_q;
    byte_d      = byte_q;
    n_d         = n_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = emit_byte;
      out_last_d  = done;
      unique case (state_q)
        ST_PREFIX: begin
          pos_d = pos_q + 1'b1;
          if (in_digits && !blank_digit) lead_d = 1'b0;
          if (prefix_end) begin
            count_d = bcd_inc(count_q);
            state_d = (kind_q == BODY_NONE) ? ST_IDLE : ST_BODY;
            cnt_d   = '0;
          end
        end
        ST_BODY: begin
          if (body_end) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end

    if (load) begin
      kind_d  = cmd_i.kind;
      byte_d  = cmd_i.data;
      n_d     = cmd_i.spaces;
      pos_d   = '0;
      lead_d  = 1'b1;
      cnt_d   = '0;
      state_d = cmd_i.prefix ? ST_PREFIX : ST_BODY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      lead_q      <= 1'b1;
      cnt_q       <= '0;
      kind_q      <= BODY_NONE;
      count_q     <= COUNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      lead_q      <= lead_d;
      cnt_q       <= cnt_d;
      kind_q      <= kind_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    n_q        <= n_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign empty_o    = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign last_o     = out_last_q;

  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> cmd_valid_i)
    else $error("command popped from an empty queue");

  a_prefix_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PREFIX) |-> (pos_q <= POS_W'(LINE_DIGITS + 1)))
    else $error("prefix position out of range");

  a_space_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BODY && kind_q == BODY_SPACES) |-> (cnt_q < n_q))
    else $error("space run overran its length");

  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == bcd_t'({LINE_DIGITS{4'd9}})) |=> (count_q == bcd_t'({LINE_DIGITS{4'd9}})))
    else $error("saturated line count moved");

  a_held_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> (out_valid_q && $stable(out_byte_q) && $stable(out_last_q)))
    else $error("unaccepted output word was overwritten");

endmodule

// ----- sv/text_char_stream_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text character stream filter
// Filters a text byte stream and optionally prefixes each line with its
// line number.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (kind_i, in_byte_i) are pushed with push while full is low;
//   kind_i high marks the start of a new file. Output words (out_byte_o,
//   last_o) are read with pop while empty is low; last_o marks the final
//   byte caused by one input word. An input word that causes nothing
//   produces no output word.
//   Configuration is written through cfg_valid_i/cfg_index_i/cfg_data_i,
//   always ready; the user must write it only while the block is idle, which the block does not enforce.
// Timing:
//   An input word passes through the command queue and the back end's
//   command registers into the output register. Plain bytes stream at one
//   per cycle while pop is high. A line prefix is LINE_DIGITS digit places
//   and two spaces, a tab a run of spaces; the back end emits one byte per cycle.
// Reset and stalls:
//   Reset clears the command queue, output word and previous byte and sets
//   the line count to one. When pop stays low the back end holds, the
//   two-entry command queue fills, and full rises until the output is taken.
// ----------------------------------------------------------------------------
module text_char_stream_filter_core import tcsf_pkg::*; #(
  parameter int unsigned MAX_TAB_WIDTH = 32,
  parameter int unsigned LINE_DIGITS   = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   push,
  output logic                   full,
  input  logic                   kind_i,
  input  logic [7:0]             in_byte_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [7:0]             out_byte_o,
  output logic                   last_o
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic cmd_push;
  logic cmd_pop;
  logic queue_full;
  logic queue_valid;

  assign cfg_ready_o = 1'b1;
  assign full        = queue_full;

  tcsf_front #(
    .MAX_TAB_WIDTH (MAX_TAB_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .kind_i      (kind_i),
    .in_byte_i   (in_byte_i),
    .fifo_full_i (queue_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (front_cmd)
  );

  tcsf_cmd_fifo u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_push),
    .wr_data_i (front_cmd),
    .rd_i      (cmd_pop),
    .rd_data_o (queue_cmd),
    .full_o    (queue_full),
    .valid_o   (queue_valid)
  );

  tcsf_back #(
    .LINE_DIGITS (LINE_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule
